[rtl/sdrc_pkg.sv]
// Shared types and constants for the scan-line dark-run center block.
package sdrc_pkg;

  localparam int MAX_LINE_DEF = 1024;

  localparam int GRAY_W   = 8;
  localparam int POS_W    = 12;
  localparam int TAG_W    = 12;
  localparam int OLEN_W   = 11;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 12;
  localparam int IN_D_W   = 24;
  localparam int OUT_D_W  = 40;

  localparam logic [CFG_A_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_FIRST_POS = 2'd1;

  localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd40;
  localparam logic [POS_W-1:0]  FIRST_POS_RST = 12'd150;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [GRAY_W-1:0] gray;
  } pix_t;

endpackage

[rtl/sdrc_in_reg.sv]
// Input register stage holding one pixel transfer until the run tracker takes it.
module sdrc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sdrc_pkg::pix_t in_pix,
  input  logic          in_last,
  input  logic          advance,
  output logic          pend_v,
  output sdrc_pkg::pix_t pend_pix,
  output logic          pend_last
);

  logic           v_r;
  sdrc_pkg::pix_t pix_r;
  logic           last_r;

  assign in_tready = !v_r || advance;
  assign pend_v    = v_r;
  assign pend_pix  = pix_r;
  assign pend_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      v_r <= 1'b1;
    end else if (advance) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r  <= in_pix;
      last_r <= in_last;
    end
  end

endmodule

[rtl/sdrc_run_track.sv]
// Dark-run tracker keeping the open run and the two best closed runs of a line.
module sdrc_run_track #(
  parameter int MAX_LINE = sdrc_pkg::MAX_LINE_DEF,
  parameter int LEN_W    = $clog2(MAX_LINE + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  sdrc_pkg::pix_t              pix,
  input  logic                        last,
  input  logic [sdrc_pkg::GRAY_W-1:0] threshold,
  input  logic [sdrc_pkg::POS_W-1:0]  first_pos,
  output logic                        pair_load,
  output logic [sdrc_pkg::POS_W-1:0]  best_start,
  output logic [LEN_W-1:0]            best_len,
  output logic [sdrc_pkg::POS_W-1:0]  second_start,
  output logic [LEN_W-1:0]            second_len,
  output logic [sdrc_pkg::TAG_W-1:0]  tag
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

  logic [sdrc_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0]           cur_len_r, cur_len_nxt;
  logic [sdrc_pkg::POS_W-1:0] cur_start_r, cur_start_nxt;
  logic [LEN_W-1:0]           best_len_r, best_len_nxt;
  logic [sdrc_pkg::POS_W-1:0] best_start_r, best_start_nxt;
  logic [LEN_W-1:0]           sec_len_r, sec_len_nxt;
  logic [sdrc_pkg::POS_W-1:0] sec_start_r, sec_start_nxt;

  logic                       dark;
  logic [sdrc_pkg::POS_W-1:0] pos;
  logic [LEN_W-1:0]           run_len;
  logic [sdrc_pkg::POS_W-1:0] run_start;

  always_comb begin
    dark      = pix.gray <= threshold;
    pos       = first_pos + idx_r;
    run_len   = cur_len_r;
    run_start = cur_start_r;
    if (dark) begin
      if (cur_len_r == '0) begin
        run_start = pos;
      end
      if (cur_len_r < LEN_MAX) begin
        run_len = cur_len_r + LEN_W'(1);
      end
    end

    cur_len_nxt    = run_len;
    cur_start_nxt  = run_start;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    sec_len_nxt    = sec_len_r;
    sec_start_nxt  = sec_start_r;
    if (!dark || last) begin
      if (run_len != '0) begin
        if (run_len > best_len_r) begin
          sec_len_nxt    = best_len_r;
          sec_start_nxt  = best_start_r;
          best_len_nxt   = run_len;
          best_start_nxt = run_start;
        end else if (run_len > sec_len_r) begin
          sec_len_nxt   = run_len;
          sec_start_nxt = run_start;
        end
      end
      cur_len_nxt = '0;
    end
    idx_nxt = idx_r + sdrc_pkg::POS_W'(1);
  end

  assign pair_load    = step && last && (best_len_nxt != '0);
  assign best_start   = best_start_nxt;
  assign best_len     = best_len_nxt;
  assign second_start = sec_start_nxt;
  assign second_len   = sec_len_nxt;
  assign tag          = pix.tag;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      idx_r        <= '0;
      cur_len_r    <= '0;
      cur_start_r  <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      sec_len_r    <= '0;
      sec_start_r  <= '0;
    end else if (step) begin
      idx_r        <= idx_nxt;
      cur_len_r    <= cur_len_nxt;
      cur_start_r  <= cur_start_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      sec_len_r    <= sec_len_nxt;
      sec_start_r  <= sec_start_nxt;
    end
  end

endmodule

[rtl/sdrc_emit.sv]
// Result register holding a line's run pair, sending primary then any alternate center.
module sdrc_emit #(
  parameter int LEN_W = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pair_load,
  input  logic [sdrc_pkg::POS_W-1:0]   best_start,
  input  logic [LEN_W-1:0]             best_len,
  input  logic [sdrc_pkg::POS_W-1:0]   second_start,
  input  logic [LEN_W-1:0]             second_len,
  input  logic [sdrc_pkg::TAG_W-1:0]   tag,
  output logic                         pair_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sdrc_pkg::OUT_D_W-1:0] out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);

  logic                       v_r;
  logic                       alt_r;
  logic [sdrc_pkg::POS_W-1:0] b_start_r, s_start_r;
  logic [LEN_W-1:0]           b_len_r, s_len_r;
  logic [sdrc_pkg::TAG_W-1:0] tag_r;

  logic                       xfer;
  logic                       done;
  logic [sdrc_pkg::POS_W-1:0] sel_start;
  logic [LEN_W-1:0]           sel_len;
  logic [LEN_W+11:0]          center_ext;
  logic [LEN_W+10:0]          len_ext;

  always_comb begin
    sel_start  = alt_r ? s_start_r : b_start_r;
    sel_len    = alt_r ? s_len_r : b_len_r;
    center_ext = (LEN_W+12)'(sel_start) + (LEN_W+12)'(sel_len >> 1);
    len_ext    = (LEN_W+11)'(sel_len);
    xfer       = v_r && out_tready;
    done       = xfer && (alt_r || (s_len_r == '0));
  end

  assign pair_free  = !v_r || done;
  assign out_tvalid = v_r;
  assign out_tuser  = alt_r;
  assign out_tlast  = alt_r || (s_len_r == '0);
  assign out_tdata  = {5'd0, len_ext[sdrc_pkg::OLEN_W-1:0], tag_r,
                       center_ext[sdrc_pkg::POS_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      alt_r <= 1'b0;
    end else if (pair_load) begin
      v_r   <= 1'b1;
      alt_r <= 1'b0;
    end else if (done) begin
      v_r   <= 1'b0;
      alt_r <= 1'b0;
    end else if (xfer) begin
      alt_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_load) begin
      b_start_r <= best_start;
      b_len_r   <= best_len;
      s_start_r <= second_start;
      s_len_r   <= second_len;
      tag_r     <= tag;
    end
  end

endmodule

[rtl/scanline_dark_run_centers.sv]
// Top level of the scan-line dark-run center block.
// A last pixel reaches the output through the input register and then the result register.
// Throughput: one pixel per cycle; a last pixel waits in the input register
// while the previous line's results still occupy the result register.
// Each line's results leave one per cycle while out_tready is high, none, one or two per line.
// Reset (rst_n low at a clock edge) clears line state and restores threshold 40
// and first position 150.
module scanline_dark_run_centers #(
  parameter int MAX_LINE = sdrc_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sdrc_pkg::IN_D_W-1:0]   in_tdata,   // gray_pixel, line_tag, zero pad
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sdrc_pkg::OUT_D_W-1:0]  out_tdata,  // center_position, tag_out, run_length, pad
  output logic                          out_tuser,  // is_alternate
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [sdrc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [sdrc_pkg::CFG_D_W-1:0]  cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic [sdrc_pkg::GRAY_W-1:0] threshold_r;
  logic [sdrc_pkg::POS_W-1:0]  first_pos_r;

  sdrc_pkg::pix_t              in_pix;
  sdrc_pkg::pix_t              pend_pix;
  logic                        pend_v, pend_last;
  logic                        advance, pair_free, pair_load;
  logic [sdrc_pkg::POS_W-1:0]  best_start, second_start;
  logic [LEN_W-1:0]            best_len, second_len;
  logic [sdrc_pkg::TAG_W-1:0]  tag;

  assign in_pix.gray = in_tdata[sdrc_pkg::GRAY_W-1:0];
  assign in_pix.tag  = in_tdata[sdrc_pkg::GRAY_W+sdrc_pkg::TAG_W-1:sdrc_pkg::GRAY_W];
  assign advance     = pend_v && (!pend_last || pair_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= sdrc_pkg::THRESHOLD_RST;
      first_pos_r <= sdrc_pkg::FIRST_POS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sdrc_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata[sdrc_pkg::GRAY_W-1:0];
        sdrc_pkg::REG_FIRST_POS: first_pos_r <= cfg_wdata[sdrc_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  sdrc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pix    (in_pix),
    .in_last   (in_tlast),
    .advance   (advance),
    .pend_v    (pend_v),
    .pend_pix  (pend_pix),
    .pend_last (pend_last)
  );

  sdrc_run_track #(
    .MAX_LINE (MAX_LINE),
    .LEN_W    (LEN_W)
  ) u_run_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .pix          (pend_pix),
    .last         (pend_last),
    .threshold    (threshold_r),
    .first_pos    (first_pos_r),
    .pair_load    (pair_load),
    .best_start   (best_start),
    .best_len     (best_len),
    .second_start (second_start),
    .second_len   (second_len),
    .tag          (tag)
  );

  sdrc_emit #(
    .LEN_W (LEN_W)
  ) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_load    (pair_load),
    .best_start   (best_start),
    .best_len     (best_len),
    .second_start (second_start),
    .second_len   (second_len),
    .tag          (tag),
    .pair_free    (pair_free),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

`ifndef SYNTH
  a_alt_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("alternate result not marked last");

  a_alt_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tuser && !out_tlast) |=> (out_tvalid && out_tuser))
    else $error("alternate result missing after primary");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (pend_v && pend_last && !pair_free))
    else $error("input stalled without a pending last pixel");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    pair_load |-> pair_free)
    else $error("result pair loaded over an unsent pair");
`endif

endmodule
